// ===== hw/rtl/cau_pkg.sv =====
// ----------------------------------------------------------------------------
// cau_pkg
// Shared operation code type for the complex arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none
package cau_pkg;
   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;
endpackage
`default_nettype wire

// ===== hw/rtl/cau_div_cell.sv =====
// ----------------------------------------------------------------------------
// cau_div_cell
// One restoring-division step for both quotients, registered, with sideband.
// ----------------------------------------------------------------------------
`default_nettype none
module cau_div_cell
   import cau_pkg::*;
#(
   parameter int NUM_BITS = 112,
   parameter int DEN_BITS = 65,
   parameter int SIDE_BITS = 4
) (
   input  wire logic                 clock,
   input  wire logic                 advance,
   input  wire logic [NUM_BITS-1:0]  re_num_i,
   input  wire logic [NUM_BITS-1:0]  im_num_i,
   input  wire logic [DEN_BITS-1:0]  re_rem_i,
   input  wire logic [DEN_BITS-1:0]  im_rem_i,
   input  wire logic [DEN_BITS-1:0]  den_i,
   input  wire logic [SIDE_BITS-1:0] side_i,
   output logic      [NUM_BITS-1:0]  re_num_o,
   output logic      [NUM_BITS-1:0]  im_num_o,
   output logic      [DEN_BITS-1:0]  re_rem_o,
   output logic      [DEN_BITS-1:0]  im_rem_o,
   output logic      [DEN_BITS-1:0]  den_o,
   output logic      [SIDE_BITS-1:0] side_o
);
   logic [DEN_BITS:0] re_sh, im_sh, re_dif, im_dif;
   logic [NUM_BITS-1:0] re_num_in, im_num_in;
   logic [DEN_BITS-1:0] re_rem_in, im_rem_in;

   // numerator shifts out at the top, quotient bit shifts in at the bottom
   always_comb begin
      re_sh = {re_rem_i, re_num_i[NUM_BITS-1]};
      im_sh = {im_rem_i, im_num_i[NUM_BITS-1]};
      re_dif = re_sh - {1'b0, den_i};
      im_dif = im_sh - {1'b0, den_i};
      if (!re_dif[DEN_BITS]) begin
         re_rem_in = re_dif[DEN_BITS-1:0];
         re_num_in = {re_num_i[NUM_BITS-2:0], 1'b1};
      end else begin
         re_rem_in = re_sh[DEN_BITS-1:0];
         re_num_in = {re_num_i[NUM_BITS-2:0], 1'b0};
      end
      if (!im_dif[DEN_BITS]) begin
         im_rem_in = im_dif[DEN_BITS-1:0];
         im_num_in = {im_num_i[NUM_BITS-2:0], 1'b1};
      end else begin
         im_rem_in = im_sh[DEN_BITS-1:0];
         im_num_in = {im_num_i[NUM_BITS-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         re_num_o <= re_num_in;
         im_num_o <= im_num_in;
         re_rem_o <= re_rem_in;
         im_rem_o <= im_rem_in;
         den_o    <= den_i;
         side_o   <= side_i;
      end
   end
endmodule
`default_nettype wire

// ===== hw/rtl/complex_arithmetic_unit_core.sv =====
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_core
// Complex add, subtract, multiply and divide on signed fixed point operands.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel carries one operation item; rsp_ channel returns one result
//   item for each, in order. Both are valid/ready streams.
//   The unit is a fixed pipeline: one multiply stage, one combine stage, a
//   chain of 2*WORD_BITS+FRAC_BITS+1 divide cells (one quotient bit each) and
//   an output stage. Every operation runs the whole chain, and one item is
//   taken every cycle unless the output stalls.
//   When rsp_tvalid is high and rsp_tready is low the whole pipeline holds;
//   req_tready is high whenever the output register is empty or being taken.
//   Synchronous reset empties the pipeline; payload is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none
module complex_arithmetic_unit_core
   import cau_pkg::*;
#(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // a_real, a_imag, b_real, b_imag from bit 0 up
   input  wire logic [4*WORD_BITS-1:0] req_tdata,
   // action
   input  wire logic [1:0]             req_tuser,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // res_real, res_imag from bit 0 up
   output logic [2*WORD_BITS-1:0]      rsp_tdata,
   // div_zero, overflowed from bit 0 up
   output logic [1:0]                  rsp_tuser
);
   localparam int W = WORD_BITS;
   localparam int PB = 2 * W + 1;           // signed sum of two products
   localparam int NB = PB + FRAC_BITS;      // numerator magnitude bits
   localparam int DB = 2 * W + 1;           // denominator bits
   localparam int NCELL = NB;
   localparam int SB = 4;                   // op(2), neg re, neg im

   logic advance;
   assign advance = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   localparam int LAT = NCELL + 2;
   logic [LAT-1:0] valid_ff, valid_in;
   assign valid_in = {valid_ff[LAT-2:0], req_tvalid};
   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else if (advance) valid_ff <= valid_in;
   end

   // stage 1: six products and the add/subtract sums
   logic signed [W-1:0] ar, ai, br, bi;
   assign ar = req_tdata[W-1:0];
   assign ai = req_tdata[2*W-1:W];
   assign br = req_tdata[3*W-1:2*W];
   assign bi = req_tdata[4*W-1:3*W];
   logic signed [2*W-1:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff, d_rr_ff, d_ii_ff;
   logic signed [W:0] s_re_ff, s_im_ff;
   logic [1:0] op1_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         p_rr_ff <= ar * br;
         p_ii_ff <= ai * bi;
         p_ri_ff <= ar * bi;
         p_ir_ff <= ai * br;
         d_rr_ff <= br * br;
         d_ii_ff <= bi * bi;
         s_re_ff <= (req_tuser == OP_SUB) ? ({ar[W-1], ar} - {br[W-1], br})
                                          : ({ar[W-1], ar} + {br[W-1], br});
         s_im_ff <= (req_tuser == OP_SUB) ? ({ai[W-1], ai} - {bi[W-1], bi})
                                          : ({ai[W-1], ai} + {bi[W-1], bi});
         op1_ff  <= req_tuser;
      end
   end

   // stage 2: combine, form sign-magnitude numerators
   logic signed [PB-1:0] m_re, m_im, v_re, v_im;
   logic [PB-1:0] mag_re, mag_im;
   logic [NB-1:0] num_re_in, num_im_in;
   logic [DB-1:0] den_in;
   logic [SB-1:0] side_in;
   always_comb begin
      m_re = PB'(p_rr_ff) - PB'(p_ii_ff);
      m_im = PB'(p_ri_ff) + PB'(p_ir_ff);
      if (op1_ff == OP_DIV) begin
         v_re = PB'(p_rr_ff) + PB'(p_ii_ff);
         v_im = PB'(p_ir_ff) - PB'(p_ri_ff);
      end else if (op1_ff == OP_MUL) begin
         v_re = m_re;
         v_im = m_im;
      end else begin
         v_re = PB'(s_re_ff);
         v_im = PB'(s_im_ff);
      end
      mag_re = v_re[PB-1] ? PB'(-v_re) : PB'(v_re);
      mag_im = v_im[PB-1] ? PB'(-v_im) : PB'(v_im);
      num_re_in = {mag_re, {FRAC_BITS{1'b0}}};
      num_im_in = {mag_im, {FRAC_BITS{1'b0}}};
      den_in = {1'b0, d_rr_ff} + {1'b0, d_ii_ff};
      side_in = {v_im[PB-1], v_re[PB-1], op1_ff};
   end

   logic [NB-1:0] c_re_num [NCELL+1];
   logic [NB-1:0] c_im_num [NCELL+1];
   logic [DB-1:0] c_re_rem [NCELL+1];
   logic [DB-1:0] c_im_rem [NCELL+1];
   logic [DB-1:0] c_den    [NCELL+1];
   logic [SB-1:0] c_side   [NCELL+1];
   logic [NB-1:0] mag_re_ff, mag_im_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         c_re_num[0] <= num_re_in;
         c_im_num[0] <= num_im_in;
         c_re_rem[0] <= '0;
         c_im_rem[0] <= '0;
         c_den[0]    <= den_in;
         c_side[0]   <= side_in;
         mag_re_ff   <= num_re_in;
         mag_im_ff   <= num_im_in;
      end
   end

   genvar g;
   generate
      for (g = 0; g < NCELL; g++) begin : g_cell
         cau_div_cell #(.NUM_BITS(NB), .DEN_BITS(DB), .SIDE_BITS(SB)) u_cell (
            .clock    (clock),
            .advance  (advance),
            .re_num_i (c_re_num[g]),
            .im_num_i (c_im_num[g]),
            .re_rem_i (c_re_rem[g]),
            .im_rem_i (c_im_rem[g]),
            .den_i    (c_den[g]),
            .side_i   (c_side[g]),
            .re_num_o (c_re_num[g+1]),
            .im_num_o (c_im_num[g+1]),
            .re_rem_o (c_re_rem[g+1]),
            .im_rem_o (c_im_rem[g+1]),
            .den_o    (c_den[g+1]),
            .side_o   (c_side[g+1])
         );
      end
   endgenerate

   // magnitudes for non-divide ops ride a parallel delay line
   logic [NB-1:0] d_re [NCELL];
   logic [NB-1:0] d_im [NCELL];
   always_ff @(posedge clock) begin
      if (advance) begin
         d_re[0] <= mag_re_ff;
         d_im[0] <= mag_im_ff;
         for (int i = 1; i < NCELL; i++) begin
            d_re[i] <= d_re[i-1];
            d_im[i] <= d_im[i-1];
         end
      end
   end

   // output: select, scale, saturate
   logic [1:0] op_o;
   logic zero_den;
   logic [NB-1:0] q_re, q_im;
   logic [W-1:0] r_re, r_im;
   logic o_re, o_im;
   logic [NB:0] lim_re, lim_im;

   always_comb begin
      op_o = c_side[NCELL][1:0];
      zero_den = (c_den[NCELL] == '0);
      if (op_o == OP_DIV) begin
         q_re = c_re_num[NCELL];
         q_im = c_im_num[NCELL];
      end else if (op_o == OP_MUL) begin
         q_re = NB'(d_re[NCELL-1] >> (2 * FRAC_BITS));
         q_im = NB'(d_im[NCELL-1] >> (2 * FRAC_BITS));
      end else begin
         q_re = NB'(d_re[NCELL-1] >> FRAC_BITS);
         q_im = NB'(d_im[NCELL-1] >> FRAC_BITS);
      end
      lim_re = (NB+1)'({1'b0, {(W-1){1'b1}}}) + (NB+1)'(c_side[NCELL][2]);
      lim_im = (NB+1)'({1'b0, {(W-1){1'b1}}}) + (NB+1)'(c_side[NCELL][3]);
      o_re = {1'b0, q_re} > lim_re;
      o_im = {1'b0, q_im} > lim_im;
      r_re = o_re ? W'(lim_re) : W'(q_re);
      r_im = o_im ? W'(lim_im) : W'(q_im);
      if (c_side[NCELL][2]) r_re = -r_re;
      if (c_side[NCELL][3]) r_im = -r_im;
      if (op_o == OP_DIV && zero_den) begin
         r_re = '0;
         r_im = '0;
         o_re = 1'b0;
         o_im = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_tvalid <= 1'b0;
      else if (advance) rsp_tvalid <= valid_ff[LAT-1];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_tdata <= {r_im, r_re};
         rsp_tuser <= {o_re | o_im, (op_o == OP_DIV) & zero_den};
      end
   end
endmodule
`default_nettype wire

// ===== verif/tb_complex_arithmetic_unit_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_complex_arithmetic_unit_core
// Streams complex add, subtract, multiply and divide items through the unit
// with bursty input and a stalling output, and checks every result against
// an exact wide-integer calculation done in the bench itself.
// ----------------------------------------------------------------------------
module tb_complex_arithmetic_unit_core;
   import cau_pkg::*;

   localparam int WB = 32;
   localparam int FB = 16;
   localparam int LATENCY = 2 * WB + FB + 3;
   localparam longint CYCLE_LIMIT = 400000;

   typedef struct packed {
      op_type      op;
      logic [31:0] a_re;
      logic [31:0] a_im;
      logic [31:0] b_re;
      logic [31:0] b_im;
   } op_item_type;

   typedef struct packed {
      logic [31:0] re;
      logic [31:0] im;
      logic        dz;
      logic        ovf;
   } cplx_res_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [4*WB-1:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [2*WB-1:0] rsp_tdata;
   logic [1:0] rsp_tuser;

   op_item_type  pending_items[$];
   cplx_res_type expected_results[$];
   int        error_count = 0;
   longint    cycle_count = 0;
   bit        sender_hold = 1'b0;
   bit        long_stall_req = 1'b0;
   int        burst_left = 0;
   int        gap_left = 0;
   int        stall_left = 0;
   int        stall_mode = 0;

   complex_arithmetic_unit_core #(.WORD_BITS(WB), .FRAC_BITS(FB)) u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // clamp a wide signed value to the word range
   function automatic logic [31:0] clamp_word(input logic signed [199:0] v, inout logic ovf);
      if (v > 200'sd2147483647) begin
         ovf = 1'b1;
         return 32'h7fff_ffff;
      end
      if (v < -200'sd2147483648) begin
         ovf = 1'b1;
         return 32'h8000_0000;
      end
      return v[31:0];
   endfunction

   // division of signed values rounding toward zero, done on magnitudes
   function automatic logic signed [199:0] quot_trunc(input logic signed [199:0] n,
                                                       input logic signed [199:0] d);
      logic [199:0] q;
      q = (n < 0 ? -n : n) / d;
      return n < 0 ? -$signed(q) : $signed(q);
   endfunction

   function automatic cplx_res_type compute_complex(input op_item_type it);
      logic signed [199:0] ar, ai, br, bi, re, im, den, m;
      cplx_res_type r;
      ar = $signed(it.a_re);
      ai = $signed(it.a_im);
      br = $signed(it.b_re);
      bi = $signed(it.b_im);
      r = '0;
      case (it.op)
         OP_ADD: begin re = ar + br; im = ai + bi; end
         OP_SUB: begin re = ar - br; im = ai - bi; end
         OP_MUL: begin
            re = ar * br - ai * bi;
            im = ar * bi + ai * br;
            // shift of the magnitude: truncation toward zero
            m = re < 0 ? -re : re; m = m >> FB; re = re < 0 ? -m : m;
            m = im < 0 ? -im : im; m = m >> FB; im = im < 0 ? -m : m;
         end
         default: begin
            den = br * br + bi * bi;
            if (den == 0) begin
               r.dz = 1'b1; re = 0; im = 0;
            end else begin
               re = quot_trunc((ar * br + ai * bi) <<< FB, den);
               im = quot_trunc((ai * br - ar * bi) <<< FB, den);
            end
         end
      endcase
      r.re = clamp_word(re, r.ovf);
      r.im = clamp_word(im, r.ovf);
      return r;
   endfunction

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h0000_0000;
         3: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hffff_0000;
         4: return $signed($urandom_range(0, 2 ** 20)) - 32'sd524288;
         default: return $urandom;
      endcase
   endfunction

   task automatic queue_item(input op_type op, input logic [31:0] ar, input logic [31:0] ai,
                             input logic [31:0] br, input logic [31:0] bi);
      op_item_type it;
      it.op = op; it.a_re = ar; it.a_im = ai; it.b_re = br; it.b_im = bi;
      pending_items.push_back(it);
   endtask

   // driver
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_results.push_back(compute_complex({op_type'(req_tuser),
               req_tdata[31:0], req_tdata[63:32], req_tdata[95:64], req_tdata[127:96]}));
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req_tvalid <= 1'b0;
            end else if (pending_items.size() > 0 && !sender_hold) begin
               op_item_type it;
               it = pending_items.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= it.op;
               req_tdata <= {it.b_im, it.b_re, it.a_im, it.a_re};
               if (burst_left > 0) begin
                  burst_left <= burst_left - 1;
               end else begin
                  burst_left <= $urandom_range(0, 30);
                  gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor and receiver stall pattern
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected item re=%h im=%h flags=%b", $time,
                        rsp_tdata[31:0], rsp_tdata[63:32], rsp_tuser);
               error_count <= error_count + 1;
            end else begin
               cplx_res_type e;
               e = expected_results.pop_front();
               if ({e.re, e.im, e.ovf, e.dz} !==
                   {rsp_tdata[31:0], rsp_tdata[63:32], rsp_tuser[1], rsp_tuser[0]}) begin
                  $display({"%0t: mismatch expected re=%h im=%h dz=%b ovf=%b",
                            " actual re=%h im=%h dz=%b ovf=%b"},
                           $time, e.re, e.im, e.dz, e.ovf, rsp_tdata[31:0],
                           rsp_tdata[63:32], rsp_tuser[0], rsp_tuser[1]);
                  error_count <= error_count + 1;
               end
            end
         end
         if (long_stall_req) begin
            long_stall_req <= 1'b0;
            stall_left <= 3 * LATENCY;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
            case (stall_mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= $urandom_range(0, 3) != 0;
               default: rsp_tready <= $urandom_range(0, 1);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      op_type op;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      // directed: extremes, each operation, zero divisor, overflow
      for (int k = 0; k < 4; k++) begin
         op = op_type'(k);
         queue_item(op, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'hffff_0000);
         queue_item(op, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
         queue_item(op, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
         queue_item(op, 32'hffff_ffff, 32'h0000_0001, 32'h0000_0000, 32'h0000_0000);
         queue_item(op, 32'h0000_0000, 32'h0000_0000, 32'h0000_0001, 32'hffff_ffff);
      end
      queue_item(OP_DIV, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0000_0000, 32'h0000_0000);
      queue_item(OP_DIV, 32'h0001_0000, 32'h0000_0000, 32'h0000_0001, 32'h0000_0000);
      queue_item(OP_DIV, 32'hfffe_0000, 32'h0003_0000, 32'h0000_0000, 32'h0002_0000);
      wait (pending_items.size() == 0);
      // long receiver hold-off while the sender keeps offering
      long_stall_req <= 1'b1;
      for (int n = 0; n < 450; n++) begin
         op = op_type'($urandom_range(0, 3));
         queue_item(op, pick_value(), pick_value(),
                    $urandom_range(0, 15) == 0 ? 32'h0 : pick_value(),
                    $urandom_range(0, 15) == 0 ? 32'h0 : pick_value());
      end
      wait (pending_items.size() == 0);
      // drain completely before the second half
      sender_hold <= 1'b1;
      wait (expected_results.size() == 0 && !req_tvalid);
      sender_hold <= 1'b0;
      for (int n = 0; n < 450; n++) begin
         op = op_type'($urandom_range(0, 3));
         queue_item(op, $urandom, $urandom, pick_value(),
                    $urandom_range(0, 15) == 0 ? 32'h0 : pick_value());
      end
      wait (pending_items.size() == 0 && !req_tvalid);
      wait (expected_results.size() == 0);
      repeat (LATENCY + 20) @(posedge clock);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule
